// File: design/bcc_pkg.sv
package bcc_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int BIT_W       = 8;
    localparam int CNT_W       = 5;
    localparam int REM_A_W     = 21;
    localparam int REM_B_W     = 12;

    // generators without their leading term
    localparam logic [REM_A_W-1:0] POLY_A_LOW = 21'h06D9E3;
    localparam logic [REM_B_W-1:0] POLY_B_LOW = 12'h539;

    localparam logic [BIT_W-1:0] A_FIRST = 8'd25;
    localparam logic [BIT_W-1:0] A_LAST  = 8'd85;
    localparam logic [BIT_W-1:0] A_END   = 8'd106;
    localparam logic [BIT_W-1:0] B_FIRST = 8'd107;
    localparam logic [BIT_W-1:0] B_LAST  = 8'd132;
    localparam logic [BIT_W-1:0] B_END   = 8'd144;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FIXED  = 2'd1;
    localparam logic [1:0] ST_FAIL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         first_status;
        logic [BIT_W-1:0]   first_fix_bit;
        logic [1:0]         second_status;
        logic [BIT_W-1:0]   second_fix_bit;
        logic [REM_A_W-1:0] first_remainder;
        logic [REM_B_W-1:0] second_remainder;
        logic               empty_frame;
        logic               frame_valid;
    } out_item_t;

    typedef struct packed {
        logic             wr_en;
        logic             last;
        logic             tgl_en;
        logic [BIT_W-1:0] tgl_bit;
    } store_cmd_t;

    function automatic logic [BIT_W-1:0] code_first(input logic code_b);
        return code_b ? B_FIRST : A_FIRST;
    endfunction

    function automatic logic [BIT_W-1:0] code_last(input logic code_b);
        return code_b ? B_LAST : A_LAST;
    endfunction

    function automatic logic [BIT_W-1:0] code_end(input logic code_b);
        return code_b ? B_END : A_END;
    endfunction

    function automatic logic [REM_A_W-1:0] poly_low(input logic code_b);
        return code_b ? {{(REM_A_W-REM_B_W){1'b0}}, POLY_B_LOW} : POLY_A_LOW;
    endfunction

endpackage

// File: design/bcc_gf_step.sv
module bcc_gf_step
    import bcc_pkg::*;
(
    input  logic [REM_A_W-1:0] r_in,
    input  logic               din,
    input  logic               code_b,
    output logic [REM_A_W-1:0] r_out
);

    logic [REM_A_W:0] t_a;
    logic [REM_B_W:0] t_b;

    // one shift-and-reduce step of the polynomial division
    always_comb
    begin
        t_a = {r_in, din};
        if (t_a[REM_A_W])
        begin
            t_a = t_a ^ {1'b1, POLY_A_LOW};
        end
        t_b = {r_in[REM_B_W-1:0], din};
        if (t_b[REM_B_W])
        begin
            t_b = t_b ^ {1'b1, POLY_B_LOW};
        end
        if (code_b)
        begin
            r_out = {{(REM_A_W-REM_B_W){1'b0}}, t_b[REM_B_W-1:0]};
        end
        else
        begin
            r_out = t_a[REM_A_W-1:0];
        end
    end

endmodule

// File: design/bcc_frame_store.sv
module bcc_frame_store
    import bcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  store_cmd_t            cmd,
    input  logic [7:0]            frame_byte,
    output logic [FRAME_BITS-1:0] store_vec
);

    logic [FRAME_BITS-1:0] vec_reg;
    logic [FRAME_BITS-1:0] vec_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [BIT_W-1:0]      tgl_idx;

    assign tgl_idx   = BIT_W'(FRAME_BITS) - cmd.tgl_bit;
    assign store_vec = vec_reg;

    always_comb
    begin
        vec_next   = vec_reg;
        count_next = count_reg;
        if (cmd.wr_en)
        begin
            // first byte of a frame clears the rest
            if (count_reg == '0)
            begin
                vec_next = '0;
            end
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                if (count_reg == CNT_W'(i))
                begin
                    vec_next[FRAME_BITS-1-8*i -: 8] = frame_byte;
                end
            end
            if (cmd.last)
            begin
                count_next = '0;
            end
            else if (count_reg < CNT_W'(FRAME_BYTES))
            begin
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.tgl_en)
        begin
            vec_next[tgl_idx] = ~vec_reg[tgl_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            vec_reg   <= vec_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: design/beacon_bch_check_correct.sv
// beacon frame check and single-bit correction
//
// input channel: one frame byte per item, taken at a clock edge with start
// high and busy low; item.last_byte marks the final byte of the frame.
// bytes after the eighteenth are dropped, missing bytes read as zero.
// a byte that is not the last is stored and busy stays low.
// on the last byte busy rises and a shared shift-and-reduce unit runs:
//   first code: remainder steps, compare, then search steps and fix on a mismatch
//   second code (when present): remainder, compare, search and fix likewise
//   plus the presence test and a step that builds the result
// so the time a frame takes after its last byte depends on whether the
// searches and the second code are needed; the bit-serial remainder and
// search loops through the single reduce unit set that time.
// the result is shown on result for exactly one cycle with done high,
// in the cycle busy falls; there is no back-pressure, the receiver must
// take it then.
// reset clears the frame store, byte count and sequencer; no result is
// pending afterwards.
module beacon_bch_check_correct
    import bcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      done,
    output out_item_t result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM,
        S_CMP,
        S_SEARCH,
        S_FIX,
        S_PRES,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic                  code_b_reg, code_b_next;
    logic [BIT_W-1:0]      cnt_reg, cnt_next;
    logic [REM_A_W-1:0]    r_reg, r_next;
    logic [REM_A_W-1:0]    e_reg, e_next;
    logic [BIT_W-1:0]      fix_reg, fix_next;
    logic [1:0]            st_a_reg, st_a_next;
    logic [BIT_W-1:0]      fix_a_reg, fix_a_next;
    logic [REM_A_W-1:0]    rem_a_reg, rem_a_next;
    logic [1:0]            st_b_reg, st_b_next;
    logic [BIT_W-1:0]      fix_b_reg, fix_b_next;
    logic [REM_B_W-1:0]    rem_b_reg, rem_b_next;
    logic                  done_reg, done_next;
    out_item_t             result_reg, result_next;

    logic                  accept;
    store_cmd_t            cmd;
    logic [FRAME_BITS-1:0] vec;
    logic [BIT_W-1:0]      bit_idx;
    logic                  din;
    logic [REM_A_W-1:0]    unit_in;
    logic                  unit_din;
    logic [REM_A_W-1:0]    unit_out;
    logic [REM_A_W-1:0]    want;
    logic                  b25, b26, b37, b38, b39, b40;
    logic                  orbito, present, empty;
    logic                  code_done;
    logic [1:0]            code_st;
    logic [BIT_W-1:0]      code_fix;
    logic [REM_A_W-1:0]    code_rem;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // frame store: byte writes while idle, bit toggles from the fix step
    always_comb
    begin
        cmd.wr_en   = accept;
        cmd.last    = item.last_byte;
        cmd.tgl_en  = (state_reg == S_FIX) && (fix_reg != '0);
        cmd.tgl_bit = fix_reg;
    end

    bcc_frame_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .frame_byte (item.frame_byte),
        .store_vec  (vec)
    );

    // bit number n lives at vector index FRAME_BITS - n
    assign bit_idx = BIT_W'(FRAME_BITS) - cnt_reg;
    assign din     = (cnt_reg <= code_last(code_b_reg)) ? vec[bit_idx] : 1'b0;

    // the shared unit divides in S_REM and steps the syndrome in S_SEARCH
    assign unit_in  = (state_reg == S_SEARCH) ? e_reg : r_reg;
    assign unit_din = (state_reg == S_SEARCH) ? 1'b0 : din;

    bcc_gf_step u_step (
        .r_in   (unit_in),
        .din    (unit_din),
        .code_b (code_b_reg),
        .r_out  (unit_out)
    );

    // received check bits: 86..106 for the first code, 133..144 for the second
    assign want = code_b_reg ? {{(REM_A_W-REM_B_W){1'b0}}, vec[REM_B_W-1:0]}
                             : vec[FRAME_BITS-86 -: REM_A_W];

    // frame type bits, read from the corrected store
    assign b25 = vec[FRAME_BITS-25];
    assign b26 = vec[FRAME_BITS-26];
    assign b37 = vec[FRAME_BITS-37];
    assign b38 = vec[FRAME_BITS-38];
    assign b39 = vec[FRAME_BITS-39];
    assign b40 = vec[FRAME_BITS-40];

    assign orbito  = b26 ? !(b37 || b38 || b39) : (!b25 && !(b37 || b38 || b39 || b40));
    assign present = b25 && !orbito;
    // bytes 3 to 17 are vector bits below the first three bytes
    assign empty   = !b25 && orbito && (vec[FRAME_BITS-25:0] == '0);

    always_comb
    begin
        state_next  = state_reg;
        code_b_next = code_b_reg;
        cnt_next    = cnt_reg;
        r_next      = r_reg;
        e_next      = e_reg;
        fix_next    = fix_reg;
        st_a_next   = st_a_reg;
        fix_a_next  = fix_a_reg;
        rem_a_next  = rem_a_reg;
        st_b_next   = st_b_reg;
        fix_b_next  = fix_b_reg;
        rem_b_next  = rem_b_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        code_done   = 1'b0;
        code_st     = ST_OK;
        code_fix    = '0;
        code_rem    = r_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.last_byte)
                begin
                    code_b_next = 1'b0;
                    cnt_next    = code_first(1'b0);
                    r_next      = '0;
                    state_next  = S_REM;
                end
            end
            S_REM:
            begin
                // data bits, then degree-many zero shifts
                r_next   = unit_out;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == code_end(code_b_reg))
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (r_reg == want)
                begin
                    code_done = 1'b1;
                end
                else
                begin
                    // syndrome of the highest data bit is the reduced generator
                    e_next     = poly_low(code_b_reg);
                    cnt_next   = code_last(code_b_reg);
                    fix_next   = '0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // walk downwards so the lowest matching bit wins
                if ((r_reg ^ e_reg) == want)
                begin
                    fix_next = cnt_reg;
                end
                e_next = unit_out;
                if (cnt_reg == code_first(code_b_reg))
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_FIX:
            begin
                code_done = 1'b1;
                if (fix_reg != '0)
                begin
                    code_st  = ST_FIXED;
                    code_fix = fix_reg;
                    code_rem = want;
                end
                else
                begin
                    code_st = ST_FAIL;
                end
            end
            S_PRES:
            begin
                if (present)
                begin
                    code_b_next = 1'b1;
                    cnt_next    = code_first(1'b1);
                    r_next      = '0;
                    state_next  = S_REM;
                end
                else
                begin
                    st_b_next  = ST_ABSENT;
                    fix_b_next = '0;
                    rem_b_next = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                result_next.first_status     = st_a_reg;
                result_next.first_fix_bit    = fix_a_reg;
                result_next.second_status    = st_b_reg;
                result_next.second_fix_bit   = fix_b_reg;
                result_next.first_remainder  = rem_a_reg;
                result_next.second_remainder = rem_b_reg;
                result_next.empty_frame      = empty;
                result_next.frame_valid      = (st_a_reg != ST_FAIL) && (st_b_reg != ST_FAIL)
                                               && !empty;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // book the outcome against whichever code is running
        if (code_done)
        begin
            if (code_b_reg)
            begin
                st_b_next  = code_st;
                fix_b_next = code_fix;
                rem_b_next = code_rem[REM_B_W-1:0];
                state_next = S_OUT;
            end
            else
            begin
                st_a_next  = code_st;
                fix_a_next = code_fix;
                rem_a_next = code_rem;
                state_next = S_PRES;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            code_b_reg <= 1'b0;
            cnt_reg    <= '0;
            r_reg      <= '0;
            e_reg      <= '0;
            fix_reg    <= '0;
            st_a_reg   <= ST_OK;
            fix_a_reg  <= '0;
            rem_a_reg  <= '0;
            st_b_reg   <= ST_OK;
            fix_b_reg  <= '0;
            rem_b_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            code_b_reg <= code_b_next;
            cnt_reg    <= cnt_next;
            r_reg      <= r_next;
            e_reg      <= e_next;
            fix_reg    <= fix_next;
            st_a_reg   <= st_a_next;
            fix_a_reg  <= fix_a_next;
            rem_a_reg  <= rem_a_next;
            st_b_reg   <= st_b_next;
            fix_b_reg  <= fix_b_next;
            rem_b_reg  <= rem_b_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    // a result only appears once the sequencer has let go of the unit
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_ok_no_fix: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.first_status == ST_OK) |-> (result.first_fix_bit == '0))
        else $error("fix bit reported on a clean first code");

    a_absent_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.second_status == ST_ABSENT)
            |-> (result.second_remainder == '0) && (result.second_fix_bit == '0))
        else $error("absent second code carries data");

    a_valid_first: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.frame_valid |-> (result.first_status != ST_FAIL))
        else $error("frame valid with failed first code");

endmodule
